FILE: hdl/ffba_pkg.sv
// Package for the first-fit block allocator: payload structs, table entry type,
// action, status and configuration index codes, and reset defaults.
// No dependencies; used by the allocator and its checker.
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 25;
    localparam int SLACK_W = 8;

    localparam logic [ADDR_W-1:0]  RESET_POOL_BASE   = 32'h0010_0000;
    localparam logic [SIZE_W-1:0]  RESET_POOL_SIZE   = 25'h010_0000;
    localparam logic [SLACK_W-1:0] RESET_SPLIT_SLACK = 8'd44;

    localparam logic [SIZE_W-1:0] USED_MAX = {SIZE_W{1'b1}};

    // Action codes.
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_REINIT = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_SLACK = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [1:0]        status;
        logic [SIZE_W-1:0] used_bytes;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              in_use;
    } entry_t;

endpackage

FILE: hdl/first_fit_block_allocator.sv
// First-fit block allocator: block table in one synchronous memory, scan
// sequencer, split and free updates, configuration registers.
// Depends on ffba_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  req     | in        | req_valid / req_stall | ffba_pkg::req_t
//  rsp     | out       | rsp_valid / rsp_stall | ffba_pkg::rsp_t
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request is worked at a time. An allocate or free scans the table from entry 0; a
// match goes through UPDATE, and SPLIT when the block is split, to DONE, which loads the
// response register, and a scan that finds nothing goes to DONE. The single table read
// port is read once per cycle in a pipelined scan. Reinitialize and unused actions go
// straight to DONE. After reset the block writes table entry 0 before it takes requests.
// A stalled response waits in its register; the next request then waits in DONE if needed.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  ffba_pkg::req_t                     req_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output ffba_pkg::rsp_t                     rsp_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]        cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_SPLIT  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [ffba_pkg::ADDR_W-1:0]  pool_base_reg;
    logic [ffba_pkg::SIZE_W-1:0]  pool_size_reg;
    logic [ffba_pkg::SLACK_W-1:0] split_slack_reg;

    // Request being worked.
    logic [1:0]                  act_reg, act_next;
    logic [ffba_pkg::SIZE_W-1:0] rsize_reg, rsize_next;
    logic [ffba_pkg::ADDR_W-1:0] raddr_reg, raddr_next;

    // Scan pipeline.
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    ffba_pkg::entry_t hit_reg, hit_next;

    logic [CNT_W-1:0]            count_reg, count_next;
    logic [ffba_pkg::SIZE_W-1:0] used_reg, used_next;

    logic [ffba_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [1:0]                  res_status_reg, res_status_next;

    ffba_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    // Block table memory.
    ffba_pkg::entry_t mem [MAX_BLOCKS];
    ffba_pkg::entry_t rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ffba_pkg::entry_t wr_data;

    logic                        hit;
    logic                        last;
    logic                        split;
    logic [ffba_pkg::SIZE_W:0]   req_plus_slack;
    logic [ffba_pkg::SIZE_W-1:0] assigned;
    logic [ffba_pkg::SIZE_W:0]   used_sum;
    logic                        rsp_free;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign hit = pend_valid_reg &&
                 ((act_reg == ffba_pkg::ACT_ALLOC)
                  ? (!rd_data_reg.in_use && (rd_data_reg.size >= rsize_reg))
                  : (rd_data_reg.in_use && (rd_data_reg.start == raddr_reg)));
    assign last = (CNT_W'(pend_idx_reg) == count_reg - CNT_W'(1));

    // The split test is one bit wider so that request plus slack cannot wrap.
    assign req_plus_slack = (ffba_pkg::SIZE_W + 1)'(rsize_reg) +
                            (ffba_pkg::SIZE_W + 1)'(split_slack_reg);
    assign split    = ((ffba_pkg::SIZE_W + 1)'(hit_reg.size) > req_plus_slack) &&
                      (count_reg < CNT_MAX);
    assign assigned = split ? rsize_reg : hit_reg.size;
    assign used_sum = (ffba_pkg::SIZE_W + 1)'(used_reg) +
                      (ffba_pkg::SIZE_W + 1)'(assigned);

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        rsize_next      = rsize_reg;
        raddr_next      = raddr_reg;
        issue_next      = issue_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        case (state_reg)
            S_INIT:
            begin
                wr_en      = 1'b1;
                wr_data    = '{start: ffba_pkg::RESET_POOL_BASE,
                               size: ffba_pkg::RESET_POOL_SIZE, in_use: 1'b0};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next        = req_data.action;
                    rsize_next      = req_data.request_size;
                    raddr_next      = req_data.free_address;
                    res_addr_next   = '0;
                    res_status_next = ffba_pkg::ST_OK;
                    if (req_data.action inside {ffba_pkg::ACT_ALLOC, ffba_pkg::ACT_FREE})
                    begin
                        issue_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        if (req_data.action == ffba_pkg::ACT_REINIT)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = '{start: pool_base_reg, size: pool_size_reg,
                                           in_use: 1'b0};
                            count_next = CNT_W'(1);
                            used_next  = '0;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                // One table read issued per cycle; the data for pend_idx arrives now.
                if (hit)
                begin
                    hit_idx_next    = pend_idx_reg;
                    hit_next        = rd_data_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_UPDATE;
                end
                else if (pend_valid_reg && last)
                begin
                    res_status_next = (act_reg == ffba_pkg::ACT_ALLOC)
                                      ? ffba_pkg::ST_NO_FIT : ffba_pkg::ST_NOT_FOUND;
                    pend_valid_next = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    pend_valid_next = (issue_reg < count_reg);
                    pend_idx_next   = issue_reg[IDX_W-1:0];
                    if (issue_reg < count_reg)
                    begin
                        rd_en      = 1'b1;
                        issue_next = issue_reg + CNT_W'(1);
                    end
                end
            end
            S_UPDATE:
            begin
                wr_en   = 1'b1;
                wr_addr = hit_idx_reg;
                if (act_reg == ffba_pkg::ACT_ALLOC)
                begin
                    wr_data       = '{start: hit_reg.start, size: assigned, in_use: 1'b1};
                    used_next     = used_sum[ffba_pkg::SIZE_W]
                                    ? ffba_pkg::USED_MAX : used_sum[ffba_pkg::SIZE_W-1:0];
                    res_addr_next = hit_reg.start;
                    state_next    = split ? S_SPLIT : S_DONE;
                end
                else
                begin
                    wr_data    = '{start: hit_reg.start, size: hit_reg.size, in_use: 1'b0};
                    used_next  = (hit_reg.size > used_reg) ? '0 : used_reg - hit_reg.size;
                    state_next = S_DONE;
                end
            end
            S_SPLIT:
            begin
                // The remainder goes to the first unused entry; count is below the depth here.
                wr_en      = 1'b1;
                wr_addr    = count_reg[IDX_W-1:0];
                wr_data    = '{start: hit_reg.start + ffba_pkg::ADDR_W'(rsize_reg),
                               size: hit_reg.size - rsize_reg, in_use: 1'b0};
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next       = '{block_address: res_addr_reg,
                                       status: res_status_reg, used_bytes: used_reg};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            pend_valid_reg  <= 1'b0;
            count_reg       <= CNT_W'(1);
            used_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            pool_base_reg   <= ffba_pkg::RESET_POOL_BASE;
            pool_size_reg   <= ffba_pkg::RESET_POOL_SIZE;
            split_slack_reg <= ffba_pkg::RESET_SPLIT_SLACK;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            used_reg       <= used_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ffba_pkg::CFG_POOL_BASE:   pool_base_reg   <= cfg_data;
                    ffba_pkg::CFG_POOL_SIZE:   pool_size_reg   <= cfg_data[ffba_pkg::SIZE_W-1:0];
                    ffba_pkg::CFG_SPLIT_SLACK: split_slack_reg <= cfg_data[ffba_pkg::SLACK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        rsize_reg      <= rsize_next;
        raddr_reg      <= raddr_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_reg        <= hit_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

endmodule

FILE: hdl/ffba_checker.sv
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator.
module ffba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input ffba_pkg::rsp_t rsp_data
);

    // A waiting response is not withdrawn.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // Requests are worked one at a time, so an accepted request blocks the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken in back-to-back cycles");

    // Only a successful allocation carries an address.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ffba_pkg::ST_OK) |-> rsp_data.block_address == '0)
        else $error("failed request returned a nonzero address");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status == ffba_pkg::ST_OK) ||
                      (rsp_data.status == ffba_pkg::ST_NO_FIT) ||
                      (rsp_data.status == ffba_pkg::ST_NOT_FOUND))
        else $error("undefined status code");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

FILE: dv/first_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for first_fit_block_allocator: directed and random allocate,
// free and reinitialize requests, checked against a table model kept in the bench.
// Depends on ffba_pkg and the allocator RTL.
module first_fit_block_allocator_tb;

    localparam int ADDR_W    = ffba_pkg::ADDR_W;
    localparam int SIZE_W    = ffba_pkg::SIZE_W;
    localparam int SLACK_W   = ffba_pkg::SLACK_W;
    localparam int CFG_IDX_W = ffba_pkg::CFG_IDX_W;

    // A small table lets the random part fill it and exercise the no-split path.
    localparam int TABLE_DEPTH = 64;
    localparam int PHASES = 12;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    ffba_pkg::req_t       req_data;
    logic                 rsp_valid;
    logic                 rsp_stall;
    ffba_pkg::rsp_t       rsp_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    first_fit_block_allocator #(
        .MAX_BLOCKS(TABLE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Block table as the allocator should hold it.
    logic [ADDR_W-1:0]  tbl_start [TABLE_DEPTH];
    logic [SIZE_W-1:0]  tbl_size [TABLE_DEPTH];
    logic               tbl_busy [TABLE_DEPTH];
    int                 tbl_count;
    logic [SIZE_W-1:0]  bytes_in_use;
    logic [ADDR_W-1:0]  cfg_base;
    logic [SIZE_W-1:0]  cfg_size;
    logic [SLACK_W-1:0] cfg_slack;

    ffba_pkg::req_t request_backlog [$];
    ffba_pkg::rsp_t awaited_results [$];

    int             req_issued;
    int             req_accepts;
    int             rsp_accepts;
    int             req_seen;
    int             rsp_seen;
    int             req_gap;
    int             rsp_hold;
    int             req_calm;
    int             rsp_calm;
    int             mismatch_count;
    ffba_pkg::rsp_t want;

    function automatic void reload_table();
        tbl_start[0] = cfg_base;
        tbl_size[0] = cfg_size;
        tbl_busy[0] = 1'b0;
        tbl_count = 1;
        bytes_in_use = '0;
    endfunction

    // Applies one request to the table and returns the response it should produce.
    function automatic ffba_pkg::rsp_t allocator_outcome(ffba_pkg::req_t r);
        ffba_pkg::rsp_t res;
        bit             done;
        logic [31:0]    sum;
        res = '0;
        done = 1'b0;
        case (r.action)
            ffba_pkg::ACT_ALLOC:
            begin
                res.status = ffba_pkg::ST_NO_FIT;
                for (int i = 0; i < tbl_count && !done; i++)
                begin
                    if (!tbl_busy[i] && tbl_size[i] >= r.request_size)
                    begin
                        if (32'(tbl_size[i]) > 32'(r.request_size) + 32'(cfg_slack)
                            && tbl_count < TABLE_DEPTH)
                        begin
                            tbl_start[tbl_count] = tbl_start[i] + ADDR_W'(r.request_size);
                            tbl_size[tbl_count] = tbl_size[i] - r.request_size;
                            tbl_busy[tbl_count] = 1'b0;
                            tbl_count++;
                            tbl_size[i] = r.request_size;
                        end
                        tbl_busy[i] = 1'b1;
                        sum = 32'(bytes_in_use) + 32'(tbl_size[i]);
                        bytes_in_use = (sum > 32'(ffba_pkg::USED_MAX))
                                       ? ffba_pkg::USED_MAX : sum[SIZE_W-1:0];
                        res.block_address = tbl_start[i];
                        res.status = ffba_pkg::ST_OK;
                        done = 1'b1;
                    end
                end
            end
            ffba_pkg::ACT_FREE:
            begin
                res.status = ffba_pkg::ST_NOT_FOUND;
                for (int i = 0; i < tbl_count && !done; i++)
                begin
                    if (tbl_busy[i] && tbl_start[i] == r.free_address)
                    begin
                        tbl_busy[i] = 1'b0;
                        bytes_in_use = (tbl_size[i] > bytes_in_use) ? '0
                                                                     : bytes_in_use - tbl_size[i];
                        res.status = ffba_pkg::ST_OK;
                        done = 1'b1;
                    end
                end
            end
            ffba_pkg::ACT_REINIT: reload_table();
            default: ;
        endcase
        res.used_bytes = bytes_in_use;
        return res;
    endfunction

    // Wait for the next request or response; quiet stretches come now and then.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic queue_request(input logic [1:0] act, input logic [SIZE_W-1:0] sz,
                                 input logic [ADDR_W-1:0] addr);
        ffba_pkg::req_t r;
        r.action = act;
        r.request_size = sz;
        r.free_address = addr;
        request_backlog.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req_issued != req_accepts
               || awaited_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ffba_pkg::CFG_POOL_BASE:   cfg_base = val;
            ffba_pkg::CFG_POOL_SIZE:   cfg_size = val[SIZE_W-1:0];
            ffba_pkg::CFG_SPLIT_SLACK: cfg_slack = val[SLACK_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Request driver: a request is held until taken, then the next one follows its gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(req_valid && req_seen == req_accepts))
            begin
                req_seen = req_accepts;
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_valid <= 1'b0;
                end
                else if (request_backlog.size() > 0)
                begin
                    req_data <= request_backlog.pop_front();
                    req_issued++;
                    req_valid <= 1'b1;
                    req_gap = draw_wait(req_calm);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response side stalls for a fresh random stretch after each response it takes.
    always @(negedge clk)
    begin
        if (rsp_seen != rsp_accepts)
        begin
            rsp_seen = rsp_accepts;
            rsp_hold = draw_wait(rsp_calm);
        end
        if (rsp_hold > 0)
        begin
            rsp_hold--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Monitor: the response is checked before a same-edge request is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_accepts++;
                if (awaited_results.size() == 0)
                begin
                    $error("response with no request outstanding: %p", rsp_data);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_data.block_address !== want.block_address)
                    begin
                        $error("block_address: expected %h, got %h",
                               want.block_address, rsp_data.block_address);
                        mismatch_count++;
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                        mismatch_count++;
                    end
                    if (rsp_data.used_bytes !== want.used_bytes)
                    begin
                        $error("used_bytes: expected %h, got %h",
                               want.used_bytes, rsp_data.used_bytes);
                        mismatch_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                awaited_results.push_back(allocator_outcome(req_data));
                req_accepts++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int                 phase;
        int                 n;
        int                 roll;
        int                 j;
        int                 k;
        bit                 fill;
        logic [SIZE_W-1:0]  sz;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  data;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_issued = 0;
        req_accepts = 0;
        rsp_accepts = 0;
        req_seen = 0;
        rsp_seen = 0;
        req_gap = 0;
        rsp_hold = 0;
        req_calm = 0;
        rsp_calm = 0;
        mismatch_count = 0;
        cfg_base = ffba_pkg::RESET_POOL_BASE;
        cfg_size = ffba_pkg::RESET_POOL_SIZE;
        cfg_slack = ffba_pkg::RESET_SPLIT_SLACK;
        reload_table();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration. A zero-size request splits and shares its start with
        // the remainder, so the same address is freed twice and then not found.
        queue_request(ffba_pkg::ACT_ALLOC, 25'd0, $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'd100, $urandom());
        queue_request(ffba_pkg::ACT_FREE, SIZE_W'($urandom()), 32'h0010_0000);
        queue_request(ffba_pkg::ACT_FREE, SIZE_W'($urandom()), 32'h0010_0000);
        queue_request(ffba_pkg::ACT_FREE, SIZE_W'($urandom()), 32'h0010_0000);
        queue_request(ffba_pkg::ACT_ALLOC, 25'h1FF_FFFF, $urandom());
        queue_request(ACT_UNUSED, SIZE_W'($urandom()), $urandom());
        queue_request(ffba_pkg::ACT_FREE, SIZE_W'($urandom()), 32'hFFFF_FFFF);
        queue_request(ffba_pkg::ACT_REINIT, SIZE_W'($urandom()), $urandom());
        // Excess equal to the slack is given whole; one byte more splits.
        queue_request(ffba_pkg::ACT_ALLOC, 25'h00F_FFD4, $urandom());
        queue_request(ffba_pkg::ACT_FREE, SIZE_W'($urandom()), 32'h0010_0000);
        queue_request(ffba_pkg::ACT_ALLOC, 25'h00F_FFD3, $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'd45, $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'd0, $urandom());
        queue_request(ffba_pkg::ACT_REINIT, SIZE_W'($urandom()), $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'h010_0000, $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'd1, $urandom());

        // Pool at the top of the address space: the split remainder wraps to zero.
        wait_drained();
        write_reg(ffba_pkg::CFG_POOL_BASE, 32'hFFFF_F000);
        write_reg(ffba_pkg::CFG_POOL_SIZE, 32'h0000_2000);
        write_reg(ffba_pkg::CFG_SPLIT_SLACK, 32'h0000_0000);
        queue_request(ffba_pkg::ACT_REINIT, SIZE_W'($urandom()), $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'h000_1000, $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'h000_1000, $urandom());
        queue_request(ffba_pkg::ACT_FREE, SIZE_W'($urandom()), 32'h0000_0000);

        // Largest pool and slack, with junk above the register widths.
        wait_drained();
        write_reg(ffba_pkg::CFG_POOL_BASE, 32'h0000_0000);
        write_reg(ffba_pkg::CFG_POOL_SIZE, 32'hFFFF_FFFF);
        write_reg(ffba_pkg::CFG_SPLIT_SLACK, 32'hFFFF_FFFF);
        queue_request(ffba_pkg::ACT_REINIT, SIZE_W'($urandom()), $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'h1FF_FF00, $urandom());
        queue_request(ffba_pkg::ACT_ALLOC, 25'd0, $urandom());
        queue_request(ffba_pkg::ACT_FREE, SIZE_W'($urandom()), 32'h0000_0000);
        queue_request(ffba_pkg::ACT_ALLOC, 25'h1FF_FEFF, $urandom());

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Every fourth phase packs the table with small blocks.
            fill = (phase % 4 == 0);
            wait_drained();
            case ($urandom_range(0, 3))
                0:       data = 32'h0000_0000;
                1:       data = 32'hFF00_0000;
                2:       data = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                default: data = $urandom();
            endcase
            write_reg(ffba_pkg::CFG_POOL_BASE, data);
            if (fill)
                sz = SIZE_W'($urandom_range(4096, 65536));
            else
                case ($urandom_range(0, 5))
                    0:       sz = 25'd1;
                    1:       sz = 25'h100_0000;
                    2:       sz = SIZE_W'($urandom_range(64, 4096));
                    3:       sz = SIZE_W'($urandom());
                    default: sz = SIZE_W'($urandom_range(256, 65536));
                endcase
            data = $urandom();
            data[SIZE_W-1:0] = sz;
            write_reg(ffba_pkg::CFG_POOL_SIZE, data);
            data = $urandom();
            if (fill)
                data[SLACK_W-1:0] = '0;
            else if ($urandom_range(0, 2) == 0)
                data[SLACK_W-1:0] = {SLACK_W{1'b1}};
            write_reg(ffba_pkg::CFG_SPLIT_SLACK, data);
            if (phase == 3)
                write_reg(CFG_UNUSED, $urandom());
            if ($urandom_range(0, 4) != 0)
                queue_request(ffba_pkg::ACT_REINIT, SIZE_W'($urandom()), $urandom());

            for (n = $urandom_range(40, 56); n > 0; n--)
            begin
                while (request_backlog.size() >= 2)
                    @(negedge clk);
                roll = $urandom_range(0, 99);
                j = $urandom_range(0, tbl_count - 1);
                if (roll < 50 || (fill && roll < 85))
                begin
                    if (fill)
                        sz = SIZE_W'($urandom_range(0, 16));
                    else
                        case ($urandom_range(0, 6))
                            0:       sz = SIZE_W'($urandom_range(0, 32'(cfg_slack) + 2));
                            1, 2:    sz = SIZE_W'($urandom_range(1, 32'(cfg_size >> 2) + 1));
                            3:       sz = tbl_size[j];
                            4:       sz = SIZE_W'(32'(tbl_size[j]) - 32'(cfg_slack)
                                                  - $urandom_range(0, 1));
                            5:       sz = SIZE_W'($urandom());
                            default: sz = SIZE_W'($urandom_range(0, 64));
                        endcase
                    queue_request(ffba_pkg::ACT_ALLOC, sz, $urandom());
                end
                else if (roll < 88)
                begin
                    // Mostly give back a block that the table holds as allocated.
                    for (k = 0; k < tbl_count; k++)
                    begin
                        if (tbl_busy[(j + k) % tbl_count])
                        begin
                            j = (j + k) % tbl_count;
                            break;
                        end
                    end
                    case ($urandom_range(0, 5))
                        0:       addr = $urandom();
                        1:       addr = cfg_base;
                        default: addr = tbl_start[j];
                    endcase
                    queue_request(ffba_pkg::ACT_FREE, SIZE_W'($urandom()), addr);
                end
                else if (roll < 95)
                begin
                    queue_request(ffba_pkg::ACT_REINIT, SIZE_W'($urandom()), $urandom());
                end
                else
                begin
                    queue_request(ACT_UNUSED, SIZE_W'($urandom()), $urandom());
                end
            end
        end

        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ffba_pkg.sv
hdl/first_fit_block_allocator.sv
hdl/ffba_checker.sv
dv/first_fit_block_allocator_tb.sv
